// ===== hw/rtl/irb_pkg.sv =====
// Shared types and constants of the image resize block.
`default_nettype none
package irb_pkg;

  localparam int FRAC_W  = 16;
  localparam int SCALE_W = 23;  // Q.16 scale, integer part up to 127
  localparam int POS_W   = 33;  // 10-bit coordinate times scale

  typedef enum logic [2:0] {
    CFG_INTERP_MODE   = 3'd0,
    CFG_CORNER_ALIGN  = 3'd1,
    CFG_IN_HEIGHT     = 3'd2,
    CFG_IN_WIDTH      = 3'd3,
    CFG_OUT_HEIGHT    = 3'd4,
    CFG_OUT_WIDTH     = 3'd5,
    CFG_CHANNEL_COUNT = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic start;
    logic zero;  // divisor is zero: result is 0 at once
  } div_req_t;

endpackage
`default_nettype wire

// ===== hw/rtl/irb_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module irb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                        wdata,
  output logic      [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/irb_div.sv =====
// Restoring divider for the Q.16 scale: ({num, 16'b0}) / den, one bit per cycle.
`default_nettype none
module irb_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire irb_pkg::div_req_t             req,
  input  wire logic [6:0]                    num,
  input  wire logic [10:0]                   den,
  output logic                               busy,
  output logic [irb_pkg::SCALE_W-1:0]        quot
);
  import irb_pkg::*;

  logic [4:0]         cnt;
  logic [10:0]        rem;
  logic [10:0]        dreg;
  logic [SCALE_W-1:0] dsh;
  logic [11:0]        trial;
  logic [11:0]        diff;
  logic               ge;

  assign trial = {rem, dsh[SCALE_W-1]};
  assign ge    = trial >= {1'b0, dreg};
  assign diff  = trial - {1'b0, dreg};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      quot <= '0;
      rem  <= '0;
      dreg <= den;
      dsh  <= {num, {FRAC_W{1'b0}}};
      cnt  <= 5'(SCALE_W - 1);
      busy <= !req.zero;
    end else if (busy) begin
      dsh  <= {dsh[SCALE_W-2:0], 1'b0};
      quot <= {quot[SCALE_W-2:0], ge};
      rem  <= ge ? diff[10:0] : trial[10:0];
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 5'd1;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/image_resize_bilinear_nearest_top.sv =====
// Top level of the bilinear / nearest image resize block.
// Holds one channel-interleaved image in a single-port store. A load
// transaction leaves the store stage without waiting for the later stages. A
// compute transaction reads four samples through the one store port in
// bilinear mode, one in nearest mode and none when out of range, and the
// store stage takes the next transaction only once those reads are issued.
// After reset and after any register write, in_ready stays low while the two
// scale dividers run. The store needs no clearing pass; reading a pixel that
// was never loaded returns an undefined sample.
`default_nettype none
module image_resize_bilinear_nearest_top #(
  parameter int MAX_IN_HEIGHT = 64,
  parameter int MAX_IN_WIDTH  = 64,
  parameter int MAX_CHANNELS  = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [10:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               func,
  input  wire logic [9:0]         row,
  input  wire logic [9:0]         col,
  input  wire logic [1:0]         channel,
  input  wire logic signed [15:0] sample,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [15:0]      value,
  output logic                    status
);
  import irb_pkg::*;

  localparam int DEPTH = MAX_IN_HEIGHT * MAX_IN_WIDTH * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int YW    = (MAX_IN_HEIGHT > 1) ? $clog2(MAX_IN_HEIGHT) : 1;
  localparam int XW    = (MAX_IN_WIDTH > 1) ? $clog2(MAX_IN_WIDTH) : 1;
  localparam logic [2:0] NRD_NONE = 3'd0;
  localparam logic [2:0] NRD_NEAR = 3'd1;
  localparam logic [2:0] NRD_BIL  = 3'd4;

  // configuration
  logic        interp_mode, corner_align;
  logic [6:0]  in_height, in_width;
  logic [10:0] out_height, out_width;
  logic [2:0]  channel_count;
  logic        recalc;

  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode   <= 1'b0;
      corner_align  <= 1'b0;
      in_height     <= 7'd1;
      in_width      <= 7'd1;
      out_height    <= 11'd1;
      out_width     <= 11'd1;
      channel_count <= 3'd1;
      recalc        <= 1'b1;
    end else begin
      recalc <= cfg_we;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_INTERP_MODE:   interp_mode   <= cfg_data[0];
          CFG_CORNER_ALIGN:  corner_align  <= cfg_data[0];
          CFG_IN_HEIGHT:     in_height     <= cfg_data[6:0];
          CFG_IN_WIDTH:      in_width      <= cfg_data[6:0];
          CFG_OUT_HEIGHT:    out_height    <= cfg_data;
          CFG_OUT_WIDTH:     out_width     <= cfg_data;
          CFG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  // effective sizes
  logic [6:0] ih, iw, ihm1, iwm1;
  logic [2:0] nc;

  always_comb begin
    ih = in_height;
    if (in_height == '0) ih = 7'd1;
    else if ({4'b0, in_height} > 11'(MAX_IN_HEIGHT)) ih = 7'(MAX_IN_HEIGHT);
    iw = in_width;
    if (in_width == '0) iw = 7'd1;
    else if ({4'b0, in_width} > 11'(MAX_IN_WIDTH)) iw = 7'(MAX_IN_WIDTH);
    nc = channel_count;
    if (channel_count == '0) nc = 3'd1;
    else if ({4'b0, channel_count} > 7'(MAX_CHANNELS)) nc = 3'(MAX_CHANNELS);
  end

  assign ihm1 = ih - 7'd1;
  assign iwm1 = iw - 7'd1;

  // scale dividers
  div_req_t           hreq, wreq;
  logic [10:0]        hden, wden;
  logic               hbusy, wbusy, busy;
  logic [SCALE_W-1:0] hs, ws;

  assign hden = corner_align ? out_height - 11'd1 : out_height;
  assign wden = corner_align ? out_width - 11'd1 : out_width;
  assign hreq = {recalc, (out_height == '0) || (hden == '0)};
  assign wreq = {recalc, (out_width == '0) || (wden == '0)};

  irb_div u_hdiv (
    .clk  (clk),
    .rst  (rst),
    .req  (hreq),
    .num  (corner_align ? ihm1 : ih),
    .den  (hden),
    .busy (hbusy),
    .quot (hs)
  );

  irb_div u_wdiv (
    .clk  (clk),
    .rst  (rst),
    .req  (wreq),
    .num  (corner_align ? iwm1 : iw),
    .den  (wden),
    .busy (wbusy),
    .quot (ws)
  );

  assign busy = recalc || hbusy || wbusy;

  // pipeline flow
  logic v1, v2, v3, v4, v5, v6;
  logic free1, free2, free3, free4, free5, free6, free_o;
  logic done3, leave3, push4, rd_issue, ram_we;

  assign free_o   = !out_valid || out_ready;
  assign free6    = !v6 || free_o;
  assign free5    = !v5 || free6;
  assign free4    = !v4 || free5;
  assign free3    = !v3 || leave3;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign in_ready = !busy && free1;

  // stage 1: range checks and source positions
  logic             s1_func, s1_err, s1_ldok;
  logic [1:0]       s1_ch;
  logic [YW-1:0]    s1_row;
  logic [XW-1:0]    s1_col;
  logic [15:0]      s1_sample;
  logic [POS_W-1:0] s1_pos_y, s1_pos_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (free1) begin
      v1 <= in_valid && in_ready;
    end
    if (free1) begin
      s1_func   <= func;
      s1_ch     <= channel;
      s1_row    <= row[YW-1:0];
      s1_col    <= col[XW-1:0];
      s1_sample <= sample;
      s1_err    <= ({1'b0, row} >= out_height) || ({1'b0, col} >= out_width)
                   || ({1'b0, channel} >= nc);
      s1_ldok   <= (row < {3'b0, ih}) && (col < {3'b0, iw}) && ({1'b0, channel} < nc);
      s1_pos_y  <= POS_W'(row) * POS_W'(hs);
      s1_pos_x  <= POS_W'(col) * POS_W'(ws);
    end
  end

  // stage 2: neighbor indices and weights
  logic [6:0]  y0b, y1b, x0b, x1b, yn, xn;
  logic [15:0] fyb, fxb;
  logic [POS_W:0] pry, prx;

  always_comb begin
    if (s1_pos_y[POS_W-1:FRAC_W] > {10'b0, ihm1}) begin
      y0b = ihm1;
      fyb = '0;
    end else begin
      y0b = s1_pos_y[FRAC_W+6:FRAC_W];
      fyb = s1_pos_y[FRAC_W-1:0];
    end
    if (s1_pos_x[POS_W-1:FRAC_W] > {10'b0, iwm1}) begin
      x0b = iwm1;
      fxb = '0;
    end else begin
      x0b = s1_pos_x[FRAC_W+6:FRAC_W];
      fxb = s1_pos_x[FRAC_W-1:0];
    end
    y1b = (y0b == ihm1) ? ihm1 : y0b + 7'd1;
    x1b = (x0b == iwm1) ? iwm1 : x0b + 7'd1;
    // nearest: round half up when corners are aligned
    pry = {1'b0, s1_pos_y} + (corner_align ? (POS_W+1)'(32'h8000) : '0);
    prx = {1'b0, s1_pos_x} + (corner_align ? (POS_W+1)'(32'h8000) : '0);
    yn  = (pry[POS_W:FRAC_W] > {11'b0, ihm1}) ? ihm1 : pry[FRAC_W+6:FRAC_W];
    xn  = (prx[POS_W:FRAC_W] > {11'b0, iwm1}) ? iwm1 : prx[FRAC_W+6:FRAC_W];
  end

  logic          s2_ld, s2_we, s2_err, s2_mode;
  logic [1:0]    s2_ch;
  logic [2:0]    s2_nrd;
  logic [YW-1:0] s2_y0, s2_y1;
  logic [XW-1:0] s2_x0, s2_x1;
  logic [15:0]   s2_fy, s2_fx, s2_sample;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (free2) begin
      v2 <= v1;
    end
    if (free2) begin
      s2_ld     <= !s1_func;
      s2_we     <= !s1_func && s1_ldok;
      s2_err    <= s1_err;
      s2_mode   <= interp_mode;
      s2_ch     <= s1_ch;
      s2_sample <= s1_sample;
      s2_fy     <= fyb;
      s2_fx     <= fxb;
      if (!s1_func) begin
        s2_y0 <= s1_row;
        s2_x0 <= s1_col;
      end else begin
        s2_y0 <= interp_mode ? YW'(yn) : YW'(y0b);
        s2_x0 <= interp_mode ? XW'(xn) : XW'(x0b);
      end
      s2_y1 <= YW'(y1b);
      s2_x1 <= XW'(x1b);
      if (!s1_func || s1_err) s2_nrd <= NRD_NONE;
      else if (interp_mode)   s2_nrd <= NRD_NEAR;
      else                    s2_nrd <= NRD_BIL;
    end
  end

  // stage 3: store access sequencer
  logic          s3_ld, s3_we, s3_err, s3_mode;
  logic [1:0]    s3_ch;
  logic [2:0]    s3_nrd, s3_iss;
  logic [YW-1:0] s3_y0, s3_y1;
  logic [XW-1:0] s3_x0, s3_x1;
  logic [15:0]   s3_fy, s3_fx, s3_sample;
  logic          pend;
  logic [1:0]    pend_idx;
  logic [15:0]   rbuf [4];
  logic [YW-1:0] ysel;
  logic [XW-1:0] xsel;
  logic [AW-1:0] addr;
  logic [15:0]   rdata;

  assign done3    = (s3_iss == s3_nrd);
  assign leave3   = v3 && done3 && (s3_ld || free4);
  assign push4    = leave3 && !s3_ld;
  assign rd_issue = v3 && !done3;
  assign ram_we   = leave3 && s3_we;
  // read order: (y0,x0) (y0,x1) (y1,x0) (y1,x1)
  assign ysel = s3_iss[1] ? s3_y1 : s3_y0;
  assign xsel = s3_iss[0] ? s3_x1 : s3_x0;
  assign addr = AW'((32'(ysel) * MAX_IN_WIDTH + 32'(xsel)) * MAX_CHANNELS + 32'(s3_ch));

  irb_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (addr),
    .wdata (s3_sample),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v3   <= 1'b0;
      pend <= 1'b0;
    end else begin
      pend <= rd_issue;
      if (free3) begin
        v3 <= v2;
      end
    end
    if (pend) begin
      rbuf[pend_idx] <= rdata;
    end
    if (free3) begin
      s3_ld     <= s2_ld;
      s3_we     <= s2_we;
      s3_err    <= s2_err;
      s3_mode   <= s2_mode;
      s3_ch     <= s2_ch;
      s3_nrd    <= s2_nrd;
      s3_y0     <= s2_y0;
      s3_y1     <= s2_y1;
      s3_x0     <= s2_x0;
      s3_x1     <= s2_x1;
      s3_fy     <= s2_fy;
      s3_fx     <= s2_fx;
      s3_sample <= s2_sample;
      s3_iss    <= '0;
    end else if (rd_issue) begin
      s3_iss <= s3_iss + 3'd1;
    end
    if (rd_issue) begin
      pend_idx <= s3_iss[1:0];
    end
  end

  // stage 4: horizontal blend of each row
  logic        s4_err, s4_mode;
  logic [15:0] s4_fy, s4_fx;
  logic [15:0] s4_b [4];  // biased to unsigned

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (free4) begin
      v4 <= push4;
    end
    if (free4) begin
      s4_err  <= s3_err;
      s4_mode <= s3_mode;
      s4_fy   <= s3_fy;
      s4_fx   <= s3_fx;
      for (int k = 0; k < 4; k++) begin
        s4_b[k] <= ((pend && pend_idx == 2'(k)) ? rdata : rbuf[k]) ^ 16'h8000;
      end
    end
  end

  logic signed [16:0] d0, d1;
  logic signed [33:0] p0, p1;
  logic [31:0]        t0, t1;

  assign d0 = $signed({1'b0, s4_b[1]}) - $signed({1'b0, s4_b[0]});
  assign d1 = $signed({1'b0, s4_b[3]}) - $signed({1'b0, s4_b[2]});
  assign p0 = d0 * $signed({1'b0, s4_fx});
  assign p1 = d1 * $signed({1'b0, s4_fx});
  assign t0 = 32'($signed({2'b0, s4_b[0], 16'h0}) + p0);
  assign t1 = 32'($signed({2'b0, s4_b[2], 16'h0}) + p1);

  // stage 5: vertical blend
  logic        s5_err, s5_mode;
  logic [15:0] s5_fy, s5_near;
  logic [31:0] s5_t0, s5_t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (free5) begin
      v5 <= v4;
    end
    if (free5) begin
      s5_err  <= s4_err;
      s5_mode <= s4_mode;
      s5_fy   <= s4_fy;
      s5_near <= s4_b[0] ^ 16'h8000;
      s5_t0   <= t0;
      s5_t1   <= t1;
    end
  end

  logic signed [32:0] dt;
  logic signed [49:0] pt;

  assign dt = $signed({1'b0, s5_t1}) - $signed({1'b0, s5_t0});
  assign pt = dt * $signed({1'b0, s5_fy});

  // stage 6: exact sum of the four weighted samples
  logic        s6_err, s6_mode;
  logic [15:0] s6_near;
  logic [47:0] s6_acc;
  logic [47:0] rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (free6) begin
      v6 <= v5;
    end
    if (free6) begin
      s6_err  <= s5_err;
      s6_mode <= s5_mode;
      s6_near <= s5_near;
      s6_acc  <= 48'($signed({2'b0, s5_t0, 16'h0}) + pt);
    end
  end

  assign rnd = s6_acc + 48'h0000_8000_0000;

  // output register: zero on error, nearest sample as is, else round half up and remove bias
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free_o) begin
      out_valid <= v6;
    end
    if (free_o) begin
      status <= s6_err;
      if (s6_err)       value <= '0;
      else if (s6_mode) value <= s6_near;
      else              value <= rnd[47:32] ^ 16'h8000;
    end
  end

  // checks
  a_port_exclusive: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> !rd_issue)
    else $error("store written and read in one cycle");

  a_read_count: assert property (@(posedge clk) disable iff (rst)
    v3 |-> s3_iss <= s3_nrd)
    else $error("read sequencer overran its count");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> value == '0)
    else $error("error result carries a nonzero value");

  a_cfg_stall: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("transaction accepted before scales were updated");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the bilinear / nearest image resize block.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import irb_pkg::*;

  localparam int MAX_H = 64;
  localparam int MAX_W = 64;
  localparam int MAX_C = 4;
  localparam int DEPTH = MAX_H * MAX_W * MAX_C;
  localparam int LIMIT = 3000000;

  typedef enum logic { FN_LOAD = 1'b0, FN_COMPUTE = 1'b1 } fn_t;

  typedef struct {
    logic               func;
    logic [9:0]         row;
    logic [9:0]         col;
    logic [1:0]         ch;
    logic signed [15:0] smp;
  } pixel_req_t;

  typedef struct {
    logic signed [15:0] value;
    logic               status;
  } resized_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [10:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               func = 1'b0;
  logic [9:0]         row = '0;
  logic [9:0]         col = '0;
  logic [1:0]         channel = '0;
  logic signed [15:0] sample = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] value;
  logic               status;

  image_resize_bilinear_nearest_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .row(row), .col(col),
    .channel(channel), .sample(sample), .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .status(status)
  );

  always #5 clk = ~clk;

  // shadow of the block
  logic [15:0] img_mem [DEPTH];
  bit          img_written [DEPTH];
  bit          m_mode, m_align;
  int          m_ih_raw, m_iw_raw, m_oh, m_ow, m_nc_raw;

  pixel_req_t  pending_reqs[$];
  resized_t    expected_samples[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          hold_reqs = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          errors = 0;
  int          cycles = 0;
  int          n_loads = 0, n_computes = 0, n_oor = 0, n_checked = 0;

  task automatic report(input string msg);
    errors++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  function automatic int clampi(input int v, input int mx);
    if (v < 1) return 1;
    if (v > mx) return mx;
    return v;
  endfunction

  function automatic longint unsigned scale_q16(input int in_sz, input int out_sz);
    longint unsigned num, den;
    num = m_align ? in_sz - 1 : in_sz;
    den = m_align ? out_sz - 1 : out_sz;
    if (out_sz == 0 || den == 0) return 0;
    return (num << 16) / den;
  endfunction

  function automatic int pix_addr(input int r, input int c, input int ch);
    return (r * MAX_W + c) * MAX_C + ch;
  endfunction

  task automatic queue_load(input int r, input int c, input int ch, input logic [15:0] s);
    pixel_req_t q;
    q.func = FN_LOAD; q.row = 10'(r); q.col = 10'(c); q.ch = 2'(ch); q.smp = s;
    pending_reqs.push_back(q);
    n_loads++;
    if (r < clampi(m_ih_raw, MAX_H) && c < clampi(m_iw_raw, MAX_W) &&
        ch < clampi(m_nc_raw, MAX_C)) begin
      img_mem[pix_addr(r, c, ch)] = s;
      img_written[pix_addr(r, c, ch)] = 1'b1;
    end
  endtask

  // biased sample; callers load any untouched pixel first (ensure_loaded) so no undefined read occurs
  function automatic longint unsigned fetch_biased(input int r, input int c, input int ch);
    return {48'd0, img_mem[pix_addr(r, c, ch)] ^ 16'h8000};
  endfunction

  task automatic ensure_loaded(input int r, input int c, input int ch);
    if (!img_written[pix_addr(r, c, ch)])
      queue_load(r, c, ch, 16'($urandom));
  endtask

  task automatic queue_compute(input int r, input int c, input int ch);
    pixel_req_t q;
    resized_t e;
    int ih, iw, nc, y0, y1, x0, x1;
    longint unsigned hs, ws, py, px, fy, fx, acc, v;
    ih = clampi(m_ih_raw, MAX_H);
    iw = clampi(m_iw_raw, MAX_W);
    nc = clampi(m_nc_raw, MAX_C);
    n_computes++;
    if (r >= m_oh || c >= m_ow || ch >= nc) begin
      e.value = '0; e.status = 1'b1;
      n_oor++;
    end else begin
      hs = scale_q16(ih, m_oh);
      ws = scale_q16(iw, m_ow);
      py = r * hs;
      px = c * ws;
      if (m_mode) begin
        if (m_align) begin
          py = (py + 64'h8000) >> 16; px = (px + 64'h8000) >> 16;
        end else begin
          py = py >> 16; px = px >> 16;
        end
        y0 = (py > ih - 1) ? ih - 1 : int'(py);
        x0 = (px > iw - 1) ? iw - 1 : int'(px);
        ensure_loaded(y0, x0, ch);
        v = fetch_biased(y0, x0, ch) - 32768;
      end else begin
        fy = py & 64'hFFFF; fx = px & 64'hFFFF;
        py = py >> 16; px = px >> 16;
        if (py > ih - 1) begin py = ih - 1; fy = 0; end
        if (px > iw - 1) begin px = iw - 1; fx = 0; end
        y0 = int'(py); x0 = int'(px);
        y1 = (y0 + 1 > ih - 1) ? ih - 1 : y0 + 1;
        x1 = (x0 + 1 > iw - 1) ? iw - 1 : x0 + 1;
        ensure_loaded(y0, x0, ch); ensure_loaded(y1, x0, ch);
        ensure_loaded(y0, x1, ch); ensure_loaded(y1, x1, ch);
        acc = fetch_biased(y0, x0, ch) * ((65536 - fy) * (65536 - fx))
            + fetch_biased(y1, x0, ch) * (fy * (65536 - fx))
            + fetch_biased(y0, x1, ch) * ((65536 - fy) * fx)
            + fetch_biased(y1, x1, ch) * (fy * fx);
        v = ((acc + 64'h8000_0000) >> 32) - 32768;
      end
      e.value = v[15:0]; e.status = 1'b0;
    end
    q.func = FN_COMPUTE; q.row = 10'(r); q.col = 10'(c); q.ch = 2'(ch);
    q.smp = 16'($urandom);
    pending_reqs.push_back(q);
    expected_samples.push_back(e);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input int data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[10:0];
    case (idx)
      CFG_INTERP_MODE:   m_mode = data[0];
      CFG_CORNER_ALIGN:  m_align = data[0];
      CFG_IN_HEIGHT:     m_ih_raw = data & 'h7F;
      CFG_IN_WIDTH:      m_iw_raw = data & 'h7F;
      CFG_OUT_HEIGHT:    m_oh = data & 'h7FF;
      CFG_OUT_WIDTH:     m_ow = data & 'h7FF;
      CFG_CHANNEL_COUNT: m_nc_raw = data & 'h7;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input int mode, input int align, input int ih, input int iw,
                           input int oh, input int ow, input int nc);
    set_reg(CFG_INTERP_MODE, mode);
    set_reg(CFG_CORNER_ALIGN, align);
    set_reg(CFG_IN_HEIGHT, ih);
    set_reg(CFG_IN_WIDTH, iw);
    set_reg(CFG_OUT_HEIGHT, oh);
    set_reg(CFG_OUT_WIDTH, ow);
    set_reg(CFG_CHANNEL_COUNT, nc);
  endtask

  task automatic wait_drained();
    wait (pending_reqs.size() == 0 && !in_valid && expected_samples.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  // n counts every queued transaction, including loads added to cover reads
  task automatic random_items(input int n);
    int goal, p, rmax, cmax;
    goal = n_loads + n_computes + n;
    while (n_loads + n_computes < goal) begin
      p = $urandom_range(99);
      rmax = (m_oh > 1024 ? 1024 : m_oh) - 1;
      cmax = (m_ow > 1024 ? 1024 : m_ow) - 1;
      if (p < 55 && rmax >= 0 && cmax >= 0)
        queue_compute($urandom_range(rmax), $urandom_range(cmax),
                      $urandom_range(clampi(m_nc_raw, MAX_C) - 1));
      else if (p < 65)
        queue_compute($urandom_range(1023), $urandom_range(1023), $urandom_range(3));
      else if (p < 90)
        queue_load($urandom_range(clampi(m_ih_raw, MAX_H) - 1),
                   $urandom_range(clampi(m_iw_raw, MAX_W) - 1),
                   $urandom_range(clampi(m_nc_raw, MAX_C) - 1), 16'($urandom));
      else
        queue_load($urandom_range(1023), $urandom_range(1023), $urandom_range(3),
                   16'($urandom));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst && (!in_valid || in_ready)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pixel_req_t q;
        q = pending_reqs.pop_front();
        in_valid <= 1'b1;
        func <= q.func; row <= q.row; col <= q.col; channel <= q.ch; sample <= q.smp;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 600;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          report("result with nothing expected");
        end else begin
          resized_t e;
          e = expected_samples.pop_front();
          n_checked++;
          if (status !== e.status)
            report($sformatf("status %b, expected %b", status, e.status));
          if (value !== e.value)
            report($sformatf("value %0d, expected %0d", value, e.value));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int ph;
    for (int i = 0; i < DEPTH; i++) begin
      img_mem[i] = '0;
      img_written[i] = 1'b0;
    end
    m_mode = 0; m_align = 0; m_ih_raw = 1; m_iw_raw = 1; m_oh = 1; m_ow = 1; m_nc_raw = 1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset sizes: single pixel, extremes of the sample and out-of-range requests
    queue_load(0, 0, 0, 16'sh7FFF);
    queue_compute(0, 0, 0);
    queue_load(0, 0, 0, 16'sh8000);
    queue_compute(0, 0, 0);
    queue_load(1023, 1023, 3, 16'h1234);   // ignored
    queue_compute(1023, 1023, 3);
    queue_compute(0, 1, 0);
    queue_compute(1, 0, 0);
    queue_compute(0, 0, 1);
    wait_drained();

    // small image, height upscaled and width downscaled, fractions on both axes, corners
    configure(0, 0, 5, 7, 13, 3, 3);
    queue_compute(0, 0, 0);
    queue_compute(12, 2, 2);
    queue_compute(6, 1, 1);
    queue_compute(13, 0, 0);
    queue_compute(0, 3, 0);
    queue_load(4, 6, 2, 16'sh7FFF);
    queue_load(5, 0, 0, 16'h0);            // ignored
    queue_compute(12, 2, 2);
    random_items(140);
    wait_drained();

    // nearest, aligned, largest sizes, sender idle
    send_idle_pct = 82;
    configure(1, 1, 64, 64, 1024, 1024, 4);
    queue_compute(1023, 1023, 3);
    queue_compute(0, 0, 0);
    queue_compute(511, 512, 1);
    random_items(150);
    wait_drained();

    // bilinear aligned with one output row: zero divisor, receiver stall
    send_idle_pct = 0; recv_stall_pct = 82;
    configure(0, 1, 64, 9, 1, 17, 4);
    random_items(140);
    wait_drained();

    // out-of-range register values and an empty output image, under pressure
    recv_stall_pct = 7; send_idle_pct = 7;
    configure(1, 0, 0, 127, 0, 2047, 0);
    hold_reqs++;
    random_items(80);
    wait_drained();
    configure(0, 0, 3, 127, 1024, 100, 7);
    hold_reqs++;
    random_items(160);
    wait_drained();

    // random settings, mostly small images
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? 82 : 0;
      recv_stall_pct = (ph >= 2) ? 82 : 7;
      configure($urandom_range(1), $urandom_range(1), $urandom_range(1, 12),
                $urandom_range(1, 12), $urandom_range(1, 40), $urandom_range(1, 40),
                $urandom_range(1, 4));
      random_items(110);
      wait_drained();
    end

    $display("covered %0d loads and %0d computes (%0d out of range), %0d results checked",
             n_loads, n_computes, n_oor, n_checked);
    $display("both modes, aligned and not, sizes from 1 to max, clamped registers, stalls");
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/irb_pkg.sv
hw/rtl/irb_ram.sv
hw/rtl/irb_div.sv
hw/rtl/image_resize_bilinear_nearest_top.sv
sim/tb_top.sv
